### design/arpc_pkg.sv
// Shared types, codes and sizes for the ARP responder with address cache.
package arpc_pkg;

  // Number of entries in the learned-address cache.
  localparam int unsigned CACHE_DEPTH = 16;
  localparam int unsigned SLOT_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_DEPTH + 1);

  localparam int unsigned MAC_W = 48;
  localparam int unsigned IP_W = 32;
  localparam int unsigned ENTRY_W = MAC_W + IP_W;

  // ARP header values that the responder accepts.
  localparam logic [15:0] HW_TYPE_ETH = 16'h0001;
  localparam logic [15:0] PROTO_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0] HW_LEN_ETH = 8'd6;
  localparam logic [7:0] PROTO_LEN_IPV4 = 8'd4;
  localparam logic [15:0] OPER_REQUEST = 16'd1;
  localparam logic [15:0] OPER_REPLY = 16'd2;

  // Item kinds.
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_LOCAL_MAC = 1'b0;
  localparam logic CFG_LOCAL_IP = 1'b1;

  typedef enum logic [3:0] {
    STAT_BAD_PROTO  = 4'd0,
    STAT_BAD_LEN    = 4'd1,
    STAT_OWN_SENDER = 4'd2,
    STAT_REPLIED    = 4'd3,
    STAT_NOT_OURS   = 4'd4,
    STAT_LEARNED    = 4'd5,
    STAT_BAD_OPCODE = 4'd6,
    STAT_HIT        = 4'd7,
    STAT_MISS       = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  // Commands from the control logic to the cache.
  typedef struct packed {
    logic insert;
    logic lookup;
  } cache_req_t;

  // Lookup completion from the cache.
  typedef struct packed {
    logic done;
    logic hit;
  } cache_rsp_t;

endpackage

### design/arp_responder_with_cache.sv
// ARP responder for IPv4 over Ethernet with a 16-entry FIFO address cache.
// Each accepted item gives exactly one result. A received ARP packet is
// classified in the cycle it is accepted and its result is registered at the
// end of that cycle; a learned reply is written to the cache at that same edge.
// A lookup scans the valid cache entries oldest to newest through the cache
// RAM's single read port, one entry per cycle.
// One item is in flight at a time; the result waits in an output register,
// and the next item is taken in the cycle that result is taken. The address
// registers are written through the configuration port, which is always ready,
// and should be written only while no item is in flight.
module arp_responder_with_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [arpc_pkg::MAC_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [15:0]                hw_type_i,
  input  logic [15:0]                proto_type_i,
  input  logic [7:0]                 hw_len_i,
  input  logic [7:0]                 proto_len_i,
  input  logic [15:0]                opcode_i,
  input  logic [arpc_pkg::MAC_W-1:0] sender_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]  sender_ip_i,
  input  logic [arpc_pkg::IP_W-1:0]  target_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0] frame_source_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]  query_ip_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 status_o,
  output logic                       reply_valid_o,
  output logic [arpc_pkg::IP_W-1:0]  reply_target_ip_o,
  output logic [arpc_pkg::MAC_W-1:0] reply_target_mac_o,
  output logic [arpc_pkg::MAC_W-1:0] reply_dst_mac_o,
  output logic [arpc_pkg::MAC_W-1:0] lookup_mac_o
);

  arpc_pkg::state_e             state_q, state_d;
  logic [arpc_pkg::MAC_W-1:0]   local_mac_q;
  logic [arpc_pkg::IP_W-1:0]    local_ip_q;
  logic                         out_valid_q, out_valid_d;
  arpc_pkg::status_e            status_q, status_d, pkt_status;
  logic                         reply_valid_q, reply_valid_d;
  logic [arpc_pkg::IP_W-1:0]    reply_ip_q, reply_ip_d;
  logic [arpc_pkg::MAC_W-1:0]   reply_mac_q, reply_mac_d;
  logic [arpc_pkg::MAC_W-1:0]   dst_mac_q, dst_mac_d;
  logic [arpc_pkg::MAC_W-1:0]   lookup_mac_q, lookup_mac_d;
  logic                         out_free, accept;
  arpc_pkg::cache_req_t         cache_req;
  arpc_pkg::cache_rsp_t         cache_rsp;
  logic [arpc_pkg::MAC_W-1:0]   cache_mac;

  assign cfg_ready_o = 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == arpc_pkg::ST_IDLE) && out_free;
  assign accept = in_valid_i && in_ready_o;

  // Packet checks, in priority order.
  always_comb begin
    if (hw_type_i != arpc_pkg::HW_TYPE_ETH || proto_type_i != arpc_pkg::PROTO_TYPE_IPV4) begin
      pkt_status = arpc_pkg::STAT_BAD_PROTO;
    end else if (hw_len_i != arpc_pkg::HW_LEN_ETH || proto_len_i != arpc_pkg::PROTO_LEN_IPV4) begin
      pkt_status = arpc_pkg::STAT_BAD_LEN;
    end else if (sender_mac_i == local_mac_q) begin
      pkt_status = arpc_pkg::STAT_OWN_SENDER;
    end else if (opcode_i == arpc_pkg::OPER_REQUEST) begin
      pkt_status = (target_ip_i == local_ip_q) ? arpc_pkg::STAT_REPLIED :
                   arpc_pkg::STAT_NOT_OURS;
    end else if (opcode_i == arpc_pkg::OPER_REPLY) begin
      pkt_status = arpc_pkg::STAT_LEARNED;
    end else begin
      pkt_status = arpc_pkg::STAT_BAD_OPCODE;
    end
  end

  assign cache_req.insert = accept && action_i == arpc_pkg::ACT_PACKET &&
                            pkt_status == arpc_pkg::STAT_LEARNED;
  assign cache_req.lookup = accept && action_i == arpc_pkg::ACT_LOOKUP;

  arpc_cache u_cache (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cache_req),
    .ins_ip_i  (sender_ip_i),
    .ins_mac_i (sender_mac_i),
    .query_ip_i(query_ip_i),
    .rsp_o     (cache_rsp),
    .mac_o     (cache_mac)
  );

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q;
    reply_valid_d = reply_valid_q;
    reply_ip_d = reply_ip_q;
    reply_mac_d = reply_mac_q;
    dst_mac_d = dst_mac_q;
    lookup_mac_d = lookup_mac_q;
    case (state_q)
      arpc_pkg::ST_IDLE: begin
        if (accept) begin
          if (action_i == arpc_pkg::ACT_LOOKUP) begin
            state_d = arpc_pkg::ST_SCAN;
          end else begin
            out_valid_d = 1'b1;
            status_d = pkt_status;
            reply_valid_d = (pkt_status == arpc_pkg::STAT_REPLIED);
            reply_ip_d = reply_valid_d ? sender_ip_i : '0;
            reply_mac_d = reply_valid_d ? sender_mac_i : '0;
            dst_mac_d = reply_valid_d ? frame_source_mac_i : '0;
            lookup_mac_d = '0;
          end
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (cache_rsp.done) begin
          state_d = arpc_pkg::ST_FLUSH;
        end
      end
      arpc_pkg::ST_FLUSH: begin
        // The cache holds its answer until the next lookup starts.
        if (out_free) begin
          state_d = arpc_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          status_d = cache_rsp.hit ? arpc_pkg::STAT_HIT : arpc_pkg::STAT_MISS;
          reply_valid_d = 1'b0;
          reply_ip_d = '0;
          reply_mac_d = '0;
          dst_mac_d = '0;
          lookup_mac_d = cache_rsp.hit ? cache_mac : '0;
        end
      end
      default: begin
        state_d = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      local_mac_q <= '0;
      local_ip_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == arpc_pkg::CFG_LOCAL_MAC) begin
          local_mac_q <= cfg_data_i;
        end else begin
          local_ip_q <= cfg_data_i[arpc_pkg::IP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    reply_valid_q <= reply_valid_d;
    reply_ip_q <= reply_ip_d;
    reply_mac_q <= reply_mac_d;
    dst_mac_q <= dst_mac_d;
    lookup_mac_q <= lookup_mac_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign reply_valid_o = reply_valid_q;
  assign reply_target_ip_o = reply_ip_q;
  assign reply_target_mac_o = reply_mac_q;
  assign reply_dst_mac_o = dst_mac_q;
  assign lookup_mac_o = lookup_mac_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cache_rsp.done |-> state_q == arpc_pkg::ST_SCAN)
    else $error("cache finished a lookup outside of a scan");

  a_reply_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_valid_o |-> status_o == arpc_pkg::STAT_REPLIED)
    else $error("reply flagged without replied status");

  a_mac_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != arpc_pkg::STAT_HIT |-> lookup_mac_o == '0)
    else $error("lookup MAC nonzero without a hit");

endmodule

### design/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/arpc_cache.sv
// FIFO address cache: ring-buffer insert and an oldest-to-newest lookup scan.
module arpc_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arpc_pkg::cache_req_t          req_i,
  input  logic [arpc_pkg::IP_W-1:0]     ins_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0]    ins_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]     query_ip_i,
  output arpc_pkg::cache_rsp_t          rsp_o,
  output logic [arpc_pkg::MAC_W-1:0]    mac_o
);

  localparam int unsigned SUM_W = arpc_pkg::CNT_W + 1;

  logic [arpc_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [arpc_pkg::CNT_W-1:0]   count_q, count_d;
  logic [arpc_pkg::SLOT_W-1:0]  addr_q, addr_d;
  logic [arpc_pkg::CNT_W-1:0]   remain_q, remain_d;
  logic                         cmp_valid_q, cmp_last_q, done_q;
  logic                         hit_q, hit_d;
  logic [arpc_pkg::MAC_W-1:0]   mac_q, mac_d;
  logic [arpc_pkg::IP_W-1:0]    query_q;
  logic [SUM_W-1:0]             oldest_sum;
  logic [arpc_pkg::SLOT_W-1:0]  oldest;
  logic [arpc_pkg::SLOT_W-1:0]  raddr, raddr_inc;
  logic                         issue, last_issue, match;
  logic [arpc_pkg::ENTRY_W-1:0] rdata;

  // Oldest valid slot: write slot minus fill count, modulo the depth.
  always_comb begin
    oldest_sum = SUM_W'(slot_q) + SUM_W'(arpc_pkg::CACHE_DEPTH) - SUM_W'(count_q);
    if (oldest_sum >= SUM_W'(arpc_pkg::CACHE_DEPTH)) begin
      oldest_sum = oldest_sum - SUM_W'(arpc_pkg::CACHE_DEPTH);
    end
    oldest = oldest_sum[arpc_pkg::SLOT_W-1:0];
  end

  assign issue = req_i.lookup ? (count_q != '0) : (remain_q != '0);
  assign raddr = req_i.lookup ? oldest : addr_q;
  assign raddr_inc = (raddr == arpc_pkg::SLOT_W'(arpc_pkg::CACHE_DEPTH - 1)) ?
                     '0 : raddr + 1'b1;
  assign last_issue = req_i.lookup ? (count_q == arpc_pkg::CNT_W'(1)) :
                      (remain_q == arpc_pkg::CNT_W'(1));
  assign match = cmp_valid_q && (rdata[arpc_pkg::ENTRY_W-1 -: arpc_pkg::IP_W] == query_q);

  arpc_ram #(
    .WIDTH(arpc_pkg::ENTRY_W),
    .DEPTH(arpc_pkg::CACHE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (req_i.insert),
    .waddr_i(slot_q),
    .wdata_i({ins_ip_i, ins_mac_i}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    slot_d = slot_q;
    count_d = count_q;
    if (req_i.insert) begin
      slot_d = (slot_q == arpc_pkg::SLOT_W'(arpc_pkg::CACHE_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      if (count_q != arpc_pkg::CNT_W'(arpc_pkg::CACHE_DEPTH)) begin
        count_d = count_q + 1'b1;
      end
    end

    addr_d = addr_q;
    remain_d = remain_q;
    if (req_i.lookup) begin
      addr_d = raddr_inc;
      remain_d = (count_q != '0) ? count_q - 1'b1 : '0;
    end else if (issue) begin
      addr_d = raddr_inc;
      remain_d = remain_q - 1'b1;
    end

    // Later entries are newer, so a later match overrides an earlier one.
    hit_d = hit_q;
    mac_d = mac_q;
    if (req_i.lookup) begin
      hit_d = 1'b0;
      mac_d = '0;
    end else if (match) begin
      hit_d = 1'b1;
      mac_d = rdata[arpc_pkg::MAC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      count_q <= '0;
      addr_q <= '0;
      remain_q <= '0;
      cmp_valid_q <= 1'b0;
      cmp_last_q <= 1'b0;
      done_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      count_q <= count_d;
      addr_q <= addr_d;
      remain_q <= remain_d;
      cmp_valid_q <= issue;
      cmp_last_q <= issue && last_issue;
      done_q <= (cmp_valid_q && cmp_last_q) || (req_i.lookup && count_q == '0);
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q <= mac_d;
    if (req_i.lookup) begin
      query_q <= query_ip_i;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit = hit_q;
  assign mac_o = mac_q;

endmodule
